[hdl/slp_pkg.sv]
// slp_pkg: types, character codes, field limits and parse helpers for the
// status line parser; no dependencies, imported by every module of the block
package slp_pkg;

    localparam logic [3:0] FIELD_ESTOP        = 4'd0;
    localparam logic [3:0] FIELD_AUTO_ARM     = 4'd1;
    localparam logic [3:0] FIELD_MANUAL_START = 4'd2;
    localparam logic [3:0] FIELD_MODE         = 4'd3;
    localparam logic [3:0] FIELD_BATTERY      = 4'd4;
    localparam logic [3:0] FIELD_RPM          = 4'd5;
    localparam logic [3:0] FIELD_TARGET       = 4'd6;
    localparam logic [3:0] FIELD_THROTTLE     = 4'd7;
    localparam logic [3:0] FIELD_SEQUENCE     = 4'd8;
    localparam logic [3:0] FIELD_COUNT        = 4'd9;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] DIGITS_FLAG  = 3'd1;
    localparam logic [2:0] DIGITS_SHORT = 3'd3;
    localparam logic [2:0] DIGITS_WIDE  = 3'd5;

    localparam logic [16:0] LIMIT_FLAG     = 17'd1;
    localparam logic [16:0] LIMIT_MODE     = 17'd4;
    localparam logic [16:0] LIMIT_BYTE     = 17'd255;
    localparam logic [16:0] LIMIT_POS_RPM  = 17'd32767;
    localparam logic [16:0] LIMIT_NEG_RPM  = 17'd32768;
    localparam logic [16:0] LIMIT_THROTTLE = 17'd65535;

    localparam logic [2:0] MODE_MAX = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } slp_word_t;

    typedef struct packed {
        logic      valid;
        slp_word_t word;
    } slp_stage_t;

    typedef struct packed {
        logic [3:0]  field_index;
        logic [2:0]  digit_count;
        logic [16:0] accumulator;
        logic        minus_seen;
        logic        field_nonempty;
        logic        line_error;
        logic [2:0]  held_flags;
        logic [2:0]  held_mode;
        logic [7:0]  held_battery;
        logic [15:0] held_rpm;
        logic [15:0] held_target;
        logic [15:0] held_throttle;
        logic [7:0]  held_sequence;
    } parse_state_t;

    typedef struct packed {
        logic        line_ok;
        logic        estop_flag;
        logic        auto_arm_flag;
        logic        manual_start_flag;
        logic [2:0]  drive_mode;
        logic [7:0]  charge_level;
        logic [15:0] measured_rpm;
        logic [15:0] commanded_rpm;
        logic [15:0] throttle_width;
        logic [7:0]  ack_sequence;
    } slp_result_t;

    function automatic logic [2:0] digit_limit(input logic [3:0] idx);
        logic [2:0] lim;
        unique case (idx) inside
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: lim = DIGITS_FLAG;
            FIELD_RPM, FIELD_TARGET, FIELD_THROTTLE:         lim = DIGITS_WIDE;
            default:                                         lim = DIGITS_SHORT;
        endcase
        return lim;
    endfunction

    function automatic logic [16:0] value_limit(input logic [3:0] idx, input logic neg);
        logic [16:0] lim;
        unique case (idx) inside
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: lim = LIMIT_FLAG;
            FIELD_MODE:                                      lim = LIMIT_MODE;
            FIELD_RPM, FIELD_TARGET: lim = neg ? LIMIT_NEG_RPM : LIMIT_POS_RPM;
            FIELD_THROTTLE:                                  lim = LIMIT_THROTTLE;
            default:                                         lim = LIMIT_BYTE;
        endcase
        return lim;
    endfunction

    // ends the current field: range check, store value, count the field
    function automatic parse_state_t close_field(input parse_state_t s);
        parse_state_t r;
        logic [15:0]  v;
        logic [15:0]  sv;
        r  = s;
        v  = s.accumulator[15:0];
        sv = s.minus_seen ? 16'(~v + 16'd1) : v;
        if (s.field_index >= FIELD_COUNT) begin
            r.line_error = 1'b1;
        end
        else begin
            if (s.digit_count == 3'd0 ||
                s.accumulator > value_limit(s.field_index, s.minus_seen)) begin
                r.line_error = 1'b1;
            end
            else begin
                unique case (s.field_index) inside
                    FIELD_ESTOP:        r.held_flags[0] = v[0];
                    FIELD_AUTO_ARM:     r.held_flags[1] = v[0];
                    FIELD_MANUAL_START: r.held_flags[2] = v[0];
                    FIELD_MODE:         r.held_mode     = v[2:0];
                    FIELD_BATTERY:      r.held_battery  = v[7:0];
                    FIELD_RPM:          r.held_rpm      = sv;
                    FIELD_TARGET:       r.held_target   = sv;
                    FIELD_THROTTLE:     r.held_throttle = v;
                    default:            r.held_sequence = v[7:0];
                endcase
            end
            r.field_index = s.field_index + 4'd1;
        end
        r.digit_count    = 3'd0;
        r.accumulator    = 17'd0;
        r.minus_seen     = 1'b0;
        r.field_nonempty = 1'b0;
        return r;
    endfunction

    // one byte of the line applied to the parse state
    function automatic parse_state_t step_byte(input parse_state_t s, input logic [7:0] c);
        parse_state_t r;
        logic         was_empty;
        r         = s;
        was_empty = !s.field_nonempty;
        if (c == CHAR_CR || c == CHAR_LF) begin
            r = s;
        end
        else if (c == CHAR_COMMA) begin
            r = close_field(s);
        end
        else begin
            r.field_nonempty = 1'b1;
            if (s.field_index >= FIELD_COUNT) begin
                r.line_error = 1'b1;
            end
            else if (c == CHAR_MINUS && was_empty &&
                     (s.field_index == FIELD_RPM || s.field_index == FIELD_TARGET)) begin
                r.minus_seen = 1'b1;
            end
            else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (s.digit_count >= digit_limit(s.field_index)) begin
                    r.line_error = 1'b1;
                end
                else begin
                    r.accumulator = 17'({s.accumulator, 3'b000} + {s.accumulator, 1'b0}
                                        + {13'd0, c[3:0]});
                    r.digit_count = s.digit_count + 3'd1;
                end
            end
            else begin
                r.line_error = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[hdl/slp_in_if.sv]
// slp_in_if: byte channel into the status line parser, valid/ready handshake
// no dependencies
interface slp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

[hdl/slp_out_if.sv]
// slp_out_if: result channel out of the status line parser, valid/ready handshake
// no dependencies
interface slp_out_if;
    logic               valid;
    logic               ready;
    logic               line_ok;
    logic               estop_flag;
    logic               auto_arm_flag;
    logic               manual_start_flag;
    logic [2:0]         drive_mode;
    logic [7:0]         charge_level;
    logic signed [15:0] measured_rpm;
    logic signed [15:0] commanded_rpm;
    logic [15:0]        throttle_width;
    logic [7:0]         ack_sequence;

    modport source (output valid, output line_ok, output estop_flag, output auto_arm_flag,
                    output manual_start_flag, output drive_mode, output charge_level,
                    output measured_rpm, output commanded_rpm, output throttle_width,
                    output ack_sequence, input ready);
    modport sink   (input valid, input line_ok, input estop_flag, input auto_arm_flag,
                    input manual_start_flag, input drive_mode, input charge_level,
                    input measured_rpm, input commanded_rpm, input throttle_width,
                    input ack_sequence, output ready);
endinterface

[hdl/slp_in_stage.sv]
// slp_in_stage: input register holding one byte word ahead of the parser
// depends on slp_pkg and slp_in_if
module slp_in_stage
    import slp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    slp_in_if.sink     in_chan,
    input  logic       take,
    output slp_stage_t stage
);

    logic      valid_reg;
    logic      valid_next;
    slp_word_t word_reg;
    logic      accept;

    assign in_chan.ready = !valid_reg || take;
    assign accept        = in_chan.valid && in_chan.ready;
    assign valid_next    = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= '{char_code: in_chan.char_code, end_of_line: in_chan.end_of_line};
        end
    end

    assign stage = '{valid: valid_reg, word: word_reg};

endmodule

[hdl/slp_parser.sv]
// slp_parser: field state update per byte and the result register
// depends on slp_pkg and slp_out_if
module slp_parser
    import slp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slp_stage_t stage,
    output logic       take,
    slp_out_if.source  out_chan
);

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t after;
    logic         out_valid_reg;
    logic         out_valid_next;
    slp_result_t  result_reg;
    slp_result_t  result_next;
    logic         out_free;
    logic         last;
    logic         ok;

    assign last     = stage.word.end_of_line;
    assign out_free = !out_valid_reg || out_chan.ready;
    assign take     = stage.valid && (!last || out_free);

    always_comb
    begin
        after = step_byte(state_reg, stage.word.char_code);
        if (last && after.field_nonempty)
        begin
            after = close_field(after);
        end
        ok = !after.line_error && (after.field_index == FIELD_COUNT);
        result_next = '0;
        if (ok)
        begin
            result_next.line_ok           = 1'b1;
            result_next.estop_flag        = after.held_flags[0];
            result_next.auto_arm_flag     = after.held_flags[1];
            result_next.manual_start_flag = after.held_flags[2];
            result_next.drive_mode        = after.held_mode;
            result_next.charge_level      = after.held_battery;
            result_next.measured_rpm      = after.held_rpm;
            result_next.commanded_rpm     = after.held_target;
            result_next.throttle_width    = after.held_throttle;
            result_next.ack_sequence      = after.held_sequence;
        end
        if (!take)
        begin
            state_next = state_reg;
        end
        else if (last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = after;
        end
    end

    assign out_valid_next = (out_valid_reg && !out_chan.ready) || (take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            result_reg <= result_next;
        end
    end

    assign out_chan.valid             = out_valid_reg;
    assign out_chan.line_ok           = result_reg.line_ok;
    assign out_chan.estop_flag        = result_reg.estop_flag;
    assign out_chan.auto_arm_flag     = result_reg.auto_arm_flag;
    assign out_chan.manual_start_flag = result_reg.manual_start_flag;
    assign out_chan.drive_mode        = result_reg.drive_mode;
    assign out_chan.charge_level      = result_reg.charge_level;
    assign out_chan.measured_rpm      = $signed(result_reg.measured_rpm);
    assign out_chan.commanded_rpm     = $signed(result_reg.commanded_rpm);
    assign out_chan.throttle_width    = result_reg.throttle_width;
    assign out_chan.ack_sequence      = result_reg.ack_sequence;

`ifndef SYNTHESIS
    a_field_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_index <= FIELD_COUNT)
        else $error("field index past field count");

    a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digit_count <= DIGITS_WIDE)
        else $error("digit count past widest field");

    a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> state_reg == '0)
        else $error("parse state not cleared after final byte");

    a_failed_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.line_ok |->
            result_reg == '0)
        else $error("failed line carries nonzero fields");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.line_ok |-> result_reg.drive_mode <= MODE_MAX)
        else $error("drive mode out of range on good line");
`endif

endmodule

[hdl/status_line_parser_core.sv]
// status_line_parser_core: top level of the status line parser
// depends on slp_pkg, slp_in_if, slp_out_if, slp_in_stage and slp_parser
//
// usage
// in_chan carries one byte word per handshake: char_code and end_of_line,
// with end_of_line set on the final byte of a line. out_chan carries one
// result word per line, produced from the final byte: line_ok plus the nine
// parsed field values, all zero when line_ok is low.
// a byte is taken into an input register, then parsed into the field state
// and, on the final byte, into the result register.
// result: the final byte is held in the input register, then parsed into the
// result register, and the output valid flag is set with it.
// throughput: one byte per cycle unless a final byte waits for the output
// register; set by the single parse step from input register to field state.
// reset: clears the field state and both valid flags; the block can take
// bytes as soon as reset is released.
// stall: the output register holds the result while out_chan.ready is low;
// bytes that are not final keep flowing, and a final byte waits in the input
// register until the output register is free.
module status_line_parser_core
    import slp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    slp_in_if.sink    in_chan,
    slp_out_if.source out_chan
);

    slp_stage_t stage;
    logic       take;

    slp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .take    (take),
        .stage   (stage)
    );

    slp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .take     (take),
        .out_chan (out_chan)
    );

endmodule

[verif/slp_line_checker.sv]
`timescale 1ns / 100ps
// slp_line_checker: watches both channels of the status line parser, predicts the
// result word of every line and compares it field by field with what comes out
// depends on slp_pkg, slp_in_if and slp_out_if
module slp_line_checker
    import slp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    slp_in_if    in_chan,
    slp_out_if   out_chan,
    output int   mismatch_count,
    output int   pending_lines
);

    typedef struct packed {
        logic [3:0]  fields_done;
        logic [2:0]  digits;
        logic [16:0] value;
        logic        negative;
        logic        has_text;
        logic        failed;
        logic [2:0]  flags;
        logic [2:0]  mode;
        logic [7:0]  battery;
        logic [15:0] rpm;
        logic [15:0] target;
        logic [15:0] throttle;
        logic [7:0]  ack_seq;
    } line_state_t;

    line_state_t line_now;
    slp_result_t expected_lines[$];
    int          results_seen;

    initial
    begin
        line_now       = '0;
        results_seen   = 0;
        mismatch_count = 0;
        pending_lines  = 0;
    end

    function automatic logic [2:0] field_width(logic [3:0] f);
        case (f)
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: return DIGITS_FLAG;
            FIELD_RPM, FIELD_TARGET, FIELD_THROTTLE:         return DIGITS_WIDE;
            default:                                         return DIGITS_SHORT;
        endcase
    endfunction

    function automatic logic [16:0] field_ceiling(logic [3:0] f, logic neg);
        case (f)
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: return LIMIT_FLAG;
            FIELD_MODE:               return LIMIT_MODE;
            FIELD_RPM, FIELD_TARGET:  return neg ? LIMIT_NEG_RPM : LIMIT_POS_RPM;
            FIELD_THROTTLE:           return LIMIT_THROTTLE;
            default:                  return LIMIT_BYTE;
        endcase
    endfunction

    task automatic end_field();
        logic [15:0] plain;
        logic [15:0] signed_bits;
        plain       = line_now.value[15:0];
        signed_bits = line_now.negative ? 16'(17'h10000 - line_now.value) : plain;
        if (line_now.fields_done >= FIELD_COUNT)
        begin
            line_now.failed = 1'b1;
        end
        else
        begin
            if (line_now.digits == 3'd0 ||
                line_now.value > field_ceiling(line_now.fields_done, line_now.negative))
            begin
                line_now.failed = 1'b1;
            end
            else
            begin
                case (line_now.fields_done)
                    FIELD_ESTOP:        line_now.flags[0]  = plain[0];
                    FIELD_AUTO_ARM:     line_now.flags[1]  = plain[0];
                    FIELD_MANUAL_START: line_now.flags[2]  = plain[0];
                    FIELD_MODE:         line_now.mode      = plain[2:0];
                    FIELD_BATTERY:      line_now.battery   = plain[7:0];
                    FIELD_RPM:          line_now.rpm       = signed_bits;
                    FIELD_TARGET:       line_now.target    = signed_bits;
                    FIELD_THROTTLE:     line_now.throttle  = plain;
                    default:            line_now.ack_seq   = plain[7:0];
                endcase
            end
            line_now.fields_done = line_now.fields_done + 4'd1;
        end
        line_now.digits   = 3'd0;
        line_now.value    = 17'd0;
        line_now.negative = 1'b0;
        line_now.has_text = 1'b0;
    endtask

    task automatic parse_char(logic [7:0] c, logic eol);
        logic        fresh;
        logic        ok;
        slp_result_t r;
        if (c == CHAR_CR || c == CHAR_LF)
        begin
        end
        else if (c == CHAR_COMMA)
        begin
            end_field();
        end
        else
        begin
            fresh             = !line_now.has_text;
            line_now.has_text = 1'b1;
            if (line_now.fields_done >= FIELD_COUNT)
                line_now.failed = 1'b1;
            else if (c == CHAR_MINUS && fresh &&
                     (line_now.fields_done == FIELD_RPM || line_now.fields_done == FIELD_TARGET))
                line_now.negative = 1'b1;
            else if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                if (line_now.digits >= field_width(line_now.fields_done))
                    line_now.failed = 1'b1;
                else
                begin
                    line_now.value  = 17'(line_now.value * 17'd10 + {13'd0, c[3:0]});
                    line_now.digits = line_now.digits + 3'd1;
                end
            end
            else
                line_now.failed = 1'b1;
        end
        if (eol)
        begin
            if (line_now.has_text)
                end_field();
            ok = !line_now.failed && line_now.fields_done == FIELD_COUNT;
            r  = '0;
            if (ok)
            begin
                r.line_ok           = 1'b1;
                r.estop_flag        = line_now.flags[0];
                r.auto_arm_flag     = line_now.flags[1];
                r.manual_start_flag = line_now.flags[2];
                r.drive_mode        = line_now.mode;
                r.charge_level      = line_now.battery;
                r.measured_rpm      = line_now.rpm;
                r.commanded_rpm     = line_now.target;
                r.throttle_width    = line_now.throttle;
                r.ack_sequence      = line_now.ack_seq;
            end
            expected_lines.insert(expected_lines.size(), r);
            line_now = '0;
        end
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < 100)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result();
        slp_result_t want;
        results_seen++;
        if (expected_lines.size() == 0)
        begin
            report_mismatch("result word with no line pending");
            return;
        end
        want = expected_lines.pop_front();
        check_field("line_ok", 16'(out_chan.line_ok), 16'(want.line_ok));
        check_field("estop_flag", 16'(out_chan.estop_flag), 16'(want.estop_flag));
        check_field("auto_arm_flag", 16'(out_chan.auto_arm_flag), 16'(want.auto_arm_flag));
        check_field("manual_start_flag", 16'(out_chan.manual_start_flag),
                    16'(want.manual_start_flag));
        check_field("drive_mode", 16'(out_chan.drive_mode), 16'(want.drive_mode));
        check_field("charge_level", 16'(out_chan.charge_level), 16'(want.charge_level));
        check_field("measured_rpm", out_chan.measured_rpm, want.measured_rpm);
        check_field("commanded_rpm", out_chan.commanded_rpm, want.commanded_rpm);
        check_field("throttle_width", out_chan.throttle_width, want.throttle_width);
        check_field("ack_sequence", 16'(out_chan.ack_sequence), 16'(want.ack_sequence));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_chan.valid && out_chan.ready)
                check_result();
            if (in_chan.valid && in_chan.ready)
                parse_char(in_chan.char_code, in_chan.end_of_line);
        end
        pending_lines = expected_lines.size();
    end

endmodule

[verif/tb_status_line_parser_core.sv]
`timescale 1ns / 100ps
// tb_status_line_parser_core: drives status lines into the parser, directed then random,
// with bursty input and a stalling receiver; depends on slp_pkg, slp_in_if, slp_out_if,
// status_line_parser_core and slp_line_checker
module tb_status_line_parser_core;
    import slp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatch_count;
    int   pending_lines;

    logic [7:0] line_bytes[$];
    int         burst_left;
    int         calm_lines;
    int         stim_chars;

    slp_in_if  in_chan();
    slp_out_if out_chan();

    status_line_parser_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    slp_line_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_chan        (in_chan),
        .out_chan       (out_chan),
        .mismatch_count (mismatch_count),
        .pending_lines  (pending_lines)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    function automatic int unsigned field_digits(int idx);
        case (idx)
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: return DIGITS_FLAG;
            FIELD_RPM, FIELD_TARGET, FIELD_THROTTLE:         return DIGITS_WIDE;
            default:                                         return DIGITS_SHORT;
        endcase
    endfunction

    function automatic int unsigned field_max(int idx, bit neg);
        case (idx)
            FIELD_ESTOP, FIELD_AUTO_ARM, FIELD_MANUAL_START: return LIMIT_FLAG;
            FIELD_MODE:              return LIMIT_MODE;
            FIELD_RPM, FIELD_TARGET: return neg ? LIMIT_NEG_RPM : LIMIT_POS_RPM;
            FIELD_THROTTLE:          return LIMIT_THROTTLE;
            default:                 return LIMIT_BYTE;
        endcase
    endfunction

    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
        int unsigned r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        if (r == 2)
            return lo + $urandom_range((hi - lo < 9) ? hi - lo : 9, 0);
        return $urandom_range(hi, lo);
    endfunction

    // stray cr/lf may land anywhere in a line
    function automatic void put_char(logic [7:0] c);
        if ($urandom_range(39, 0) == 0)
            line_bytes.insert(line_bytes.size(), $urandom_range(1, 0) ? CHAR_CR : CHAR_LF);
        line_bytes.insert(line_bytes.size(), c);
    endfunction

    function automatic void put_number(int unsigned v, int unsigned digits);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < digits)
            s = {"0", s};
        for (int i = 0; i < s.len(); i++)
            put_char(8'(s[i]));
    endfunction

    function automatic void put_good_field(int idx);
        bit neg;
        neg = 1'b0;
        if ((idx == FIELD_RPM || idx == FIELD_TARGET) && $urandom_range(1, 0))
        begin
            neg = 1'b1;
            put_char(CHAR_MINUS);
        end
        put_number(pick_value(0, field_max(idx, neg)), $urandom_range(field_digits(idx), 1));
    endfunction

    function automatic void put_bad_field(int idx);
        bit          neg;
        int unsigned hi;
        int unsigned nd;
        int unsigned top_value;
        logic [7:0]  c;
        neg = (idx == FIELD_RPM || idx == FIELD_TARGET) && $urandom_range(1, 0);
        hi  = field_max(idx, neg);
        nd  = field_digits(idx);
        top_value = 1;
        repeat (nd) top_value = top_value * 10;
        top_value = top_value - 1;
        case ($urandom_range(4, 0))
            0:
            begin
                if (neg)
                    put_char(CHAR_MINUS);
                put_number(pick_value(hi + 1, top_value), 1);
            end
            1:
            begin
                if (neg)
                    put_char(CHAR_MINUS);
                put_number(pick_value(0, hi), nd + 1);
            end
            2:
            begin
                put_good_field(idx);
                do
                    c = 8'($urandom_range(255, 0));
                while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COMMA ||
                       c == CHAR_CR || c == CHAR_LF);
                put_char(c);
            end
            3:
            begin
            end
            default: put_char(CHAR_MINUS);
        endcase
    endfunction

    function automatic void build_line(int field_total, int bad_idx);
        line_bytes.delete();
        for (int i = 0; i < field_total; i++)
        begin
            if (i > 0)
                put_char(CHAR_COMMA);
            if (i == bad_idx)
                put_bad_field(i);
            else if (i < FIELD_COUNT)
                put_good_field(i);
            else
                put_number($urandom_range(9, 0), 1);
        end
        if ($urandom_range(3, 0) == 0)
            put_char(CHAR_COMMA);
        case ($urandom_range(2, 0))
            0:
            begin
            end
            1: line_bytes.insert(line_bytes.size(), CHAR_LF);
            default:
            begin
                line_bytes.insert(line_bytes.size(), CHAR_CR);
                line_bytes.insert(line_bytes.size(), CHAR_LF);
            end
        endcase
    endfunction

    function automatic void build_noise();
        string alphabet;
        int    n;
        alphabet = "0123456789,-\015\n";
        n = $urandom_range(24, 1);
        line_bytes.delete();
        repeat (n)
        begin
            if ($urandom_range(1, 0))
                line_bytes.insert(line_bytes.size(),
                                  8'(alphabet[$urandom_range(alphabet.len() - 1, 0)]));
            else
                line_bytes.insert(line_bytes.size(), 8'($urandom_range(255, 0)));
        end
    endfunction

    task automatic send_char(logic [7:0] c, logic eol);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = (calm_lines > 0) ? 0 : $urandom_range(6, 0);
            if (gap > 0)
            begin
                in_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_chan.valid       <= 1'b1;
        in_chan.char_code   <= c;
        in_chan.end_of_line <= eol;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_line();
        if (line_bytes.size() == 0)
            line_bytes.insert(0, CHAR_LF);
        for (int i = 0; i < line_bytes.size(); i++)
        begin
            send_char(line_bytes[i], i == line_bytes.size() - 1);
            stim_chars++;
        end
    endtask

    task automatic send_text(string s);
        line_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            line_bytes.insert(line_bytes.size(), 8'(s[i]));
        send_line();
    endtask

    task automatic hold_until_drained();
        in_chan.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_lines != 0);
        @(posedge clk);
    endtask

    // receiver: changing stall patterns plus a long hold now and then
    initial
    begin
        int stall_mode;
        int mode_left;
        int hold_left;
        int cycle_no;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        cycle_no   = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 1000 == 400)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(3, 0);
                    mode_left  = $urandom_range(200, 20);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_chan.ready <= 1'b1;
                    1:       out_chan.ready <= 1'($urandom_range(1, 0));
                    2:       out_chan.ready <= ($urandom_range(4, 0) != 0);
                    default: out_chan.ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int kind;
        in_chan.valid       <= 1'b0;
        in_chan.char_code   <= 8'd0;
        in_chan.end_of_line <= 1'b0;
        burst_left = 0;
        calm_lines = 0;
        stim_chars = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0,0,0,0,0,0,0,0,0");
        send_text("1,1,1,4,255,32767,32767,65535,255");
        send_text("1,0,1,004,000,-32768,-32768,00000,000");
        send_text("0,1,0,2,100,-1,1,1500,7,");
        send_text("0,\0151,0,2,10,-\n5,3,100,7\015\n");
        hold_until_drained();
        send_text("0,0,0,0,0,0,0,0,0,1");
        send_text("0,0,0,0,0,0,0,0,0,,");
        send_text("0,0,0,0,0,0,0,0");
        send_text("0,,0,0,0,0,0,0,0");
        send_text("0,0,0,0,0,-,0,0,0");
        send_text("0,0,0,0,0,0,-,0,0");
        send_text("0,0,0,0,a,0,0,0,0");
        send_text("0,0,0,0,-5,0,0,0,0");
        send_text("0,0,0,0,0,5-,0,0,0");
        send_text("0,0,0,0,0,--5,0,0,0");
        send_text("00,0,0,0,0,0,0,0,0");
        send_text("0,0,0,0004,0,0,0,0,0");
        send_text("0,0,0,0,0,000001,0,0,0");
        send_text("2,0,0,0,0,0,0,0,0");
        send_text("0,0,0,5,256,0,0,0,0");
        send_text("0,0,0,0,0,32768,-32769,65536,256");
        send_text("1,1,1,4,255,99999,0,0,0");
        send_text("\015\n");
        send_text("\n");
        send_text("7");
        hold_until_drained();

        while (stim_chars < 1850)
        begin
            if (calm_lines > 0)
                calm_lines--;
            else if ($urandom_range(9, 0) == 0)
                calm_lines = $urandom_range(5, 1);
            kind = $urandom_range(99, 0);
            if (kind < 65)
                build_line(9, -1);
            else if (kind < 80)
                build_line(9, $urandom_range(8, 0));
            else if (kind < 86)
            begin
                case ($urandom_range(2, 0))
                    0:       build_line(8, -1);
                    1:       build_line(10, -1);
                    default:
                    begin
                        build_line(9, -1);
                        line_bytes.insert(line_bytes.size(), CHAR_COMMA);
                        line_bytes.insert(line_bytes.size(), CHAR_COMMA);
                    end
                endcase
            end
            else if (kind < 92)
            begin
                build_line(9, -1);
                line_bytes[$urandom_range(line_bytes.size() - 1, 0)] = 8'($urandom_range(255, 0));
            end
            else
                build_noise();
            send_line();
            if ($urandom_range(11, 0) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
